[rtl/core/iso_pkg.sv]
// ----------------------------------------------------------------------------
// Isodata threshold binariser package
// Sequencer states and the fixed codes and constants used by the block.
// ----------------------------------------------------------------------------
package iso_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HRD  = 7'b0000010,
    S_HWR  = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_UPD  = 7'b1000000
  } iso_state_t;

  localparam logic OP_HIST = 1'b0;
  localparam logic OP_BIN  = 1'b1;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [7:0]  WHITE   = 8'd255;
  localparam logic [7:0]  BLACK   = 8'd0;
  localparam logic [15:0] HALF_88 = 16'd128;
  localparam int          NBINS   = 256;
  localparam int          QBITS   = 16;

endpackage

[rtl/core/isodata_threshold_binarizer.sv]
// ----------------------------------------------------------------------------
// Isodata threshold binariser
// Two-pass automatic thresholding of 8-bit grey pixels with a shared divider.
// ----------------------------------------------------------------------------
// A binarise word gives its result in the cycle after acceptance.
// A histogram word passes a read state and a modify-write state, then idles.
// The last histogram word runs a bin scan, then per round a summing sweep,
// two divisions through the shared divider and an update step.
// New words stall while the sequencer is busy or a result is held back.
// Reset clears all bin valid bits and the held threshold at once.
module isodata_threshold_binarizer #(
  parameter int COUNT_BITS = 21,
  parameter int MAX_ROUNDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pix_valid,
  output logic        pix_stall,
  input  logic        opcode,
  input  logic [7:0]  pixel,
  input  logic        last_pixel,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        result_kind,
  output logic [7:0]  binary_pixel,
  output logic [15:0] threshold_value
);
  import iso_pkg::*;

  // Pixel counts per class need eight more bits than a bin; weighted sums
  // need sixteen more, since a grey level is at most eight bits.
  localparam int NW = COUNT_BITS + 8;
  localparam int SW = COUNT_BITS + 16;
  localparam int RW = $clog2(MAX_ROUNDS + 1);

  iso_state_t state;

  // The bin memory is read through a registered port; a separate valid bit
  // per bin lets the whole histogram be cleared at once.
  logic [COUNT_BITS-1:0] mem [NBINS];
  logic [NBINS-1:0]      vld;
  logic [COUNT_BITS-1:0] mem_q;
  logic                  rd_vld;
  logic [7:0]            rd_addr;
  logic [COUNT_BITS-1:0] eff;

  logic [7:0]            px;
  logic                  last;
  logic [8:0]            cnt;
  logic                  proc;
  logic [7:0]            g;

  logic                  found;
  logic [7:0]            lo;
  logic [7:0]            mode;
  logic [COUNT_BITS-1:0] best;

  logic [15:0]           told;
  logic [15:0]           held;
  logic [RW-1:0]         round;

  logic [NW-1:0]         nl, nh;
  logic [SW-1:0]         sl, sh;

  // Shared restoring divider state.
  logic [NW-1:0]         div_rem;
  logic [NW-1:0]         div_n;
  logic [QBITS-1:0]      div_q;
  logic [4:0]            div_cnt;
  logic                  div_zero;
  logic                  div_hi;
  logic [15:0]           m1;

  logic [NW:0]           r2;
  logic                  r_ge;
  logic [15:0]           div_res;

  logic [COUNT_BITS+7:0] prod;
  logic [16:0]           top_sum;
  logic [8:0]            top;
  logic                  in_lo, in_hi;
  logic [16:0]           mean_sum;
  logic [15:0]           t_new;
  logic [15:0]           diff;
  logic                  finish;
  logic                  res_busy;
  logic                  accept;
  logic                  res_load;

  assign res_busy  = res_valid && res_stall;
  assign pix_stall = (state != S_IDLE) || res_busy;
  assign accept    = pix_valid && !pix_stall;

  // A new result word is loaded by a binarise word or by the final round.
  assign res_load  = (accept && opcode == OP_BIN) ||
                     (state == S_UPD && finish && !res_busy);

  assign rd_addr = (state == S_HRD) ? px : cnt[7:0];
  assign eff     = rd_vld ? mem_q : '0;
  assign proc    = (cnt != 9'd0) && (cnt <= 9'(NBINS));
  assign g       = cnt[7:0] - 8'd1;

  assign prod    = {{COUNT_BITS{1'b0}}, g} * {8'd0, eff};
  assign top_sum = {1'b0, told} + 17'd255;
  assign top     = top_sum[16:8];
  assign in_lo   = {1'b0, g} < top;
  assign in_hi   = g >= told[15:8];

  assign r2      = {div_rem, div_q[QBITS-1]};
  assign r_ge    = r2 >= {1'b0, div_n};
  assign div_res = div_zero ? 16'd0 : div_q;

  assign mean_sum = {1'b0, m1} + {1'b0, div_res};
  assign t_new    = mean_sum[16:1];
  assign diff     = (t_new > told) ? (t_new - told) : (told - t_new);
  assign finish   = (diff <= HALF_88) || (round == RW'(MAX_ROUNDS - 1));

  always_ff @(posedge clk) begin
    mem_q  <= mem[rd_addr];
    rd_vld <= vld[rd_addr];
    if (state == S_HWR) begin
      mem[px] <= (eff == '1) ? eff : eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      held      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == OP_BIN) begin
              result_kind     <= KIND_PIXEL;
              binary_pixel    <= ({pixel, 8'h00} < held) ? BLACK : WHITE;
              threshold_value <= held;
            end else begin
              px    <= pixel;
              last  <= last_pixel;
              state <= S_HRD;
            end
          end
        end
        S_HRD: begin
          state <= S_HWR;
        end
        S_HWR: begin
          vld[px] <= 1'b1;
          if (last) begin
            cnt   <= '0;
            found <= 1'b0;
            lo    <= 8'd255;
            mode  <= 8'd0;
            best  <= '0;
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          cnt <= (cnt == 9'(NBINS + 1)) ? 9'd0 : cnt + 9'd1;
          if (proc) begin
            if (!found && eff != '0) begin
              found <= 1'b1;
              lo    <= g;
            end
            if (g != 8'd0 && eff > best) begin
              best <= eff;
              mode <= g;
            end
          end
          if (cnt == 9'(NBINS + 1)) begin
            told  <= {8'(({1'b0, lo} + {1'b0, mode}) >> 1), 8'h00};
            round <= '0;
            nl    <= '0;
            nh    <= '0;
            sl    <= '0;
            sh    <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          cnt <= cnt + 9'd1;
          if (proc) begin
            if (in_lo) begin
              nl <= nl + NW'(eff);
              sl <= sl + SW'(prod);
            end
            if (in_hi) begin
              nh <= nh + NW'(eff);
              sh <= sh + SW'(prod);
            end
          end
          if (cnt == 9'(NBINS + 1)) begin
            div_rem  <= sl[SW-1:8];
            div_q    <= {sl[7:0], 8'h00};
            div_n    <= nl;
            div_zero <= (nl == '0);
            div_cnt  <= '0;
            div_hi   <= 1'b0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt != 5'(QBITS)) begin
            div_rem <= r_ge ? NW'(r2 - {1'b0, div_n}) : r2[NW-1:0];
            div_q   <= {div_q[QBITS-2:0], r_ge};
            div_cnt <= div_cnt + 5'd1;
          end else if (!div_hi) begin
            // Lower-class mean is done; reuse the divider for the upper class.
            m1       <= div_res;
            div_rem  <= sh[SW-1:8];
            div_q    <= {sh[7:0], 8'h00};
            div_n    <= nh;
            div_zero <= (nh == '0);
            div_cnt  <= '0;
            div_hi   <= 1'b1;
          end else begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (finish) begin
            if (!res_busy) begin
              held            <= t_new;
              vld             <= '0;
              result_kind     <= KIND_REPORT;
              binary_pixel    <= BLACK;
              threshold_value <= t_new;
              state           <= S_IDLE;
            end
          end else begin
            told  <= t_new;
            round <= round + 1'b1;
            cnt   <= '0;
            nl    <= '0;
            nh    <= '0;
            sl    <= '0;
            sh    <= '0;
            state <= S_SUM;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Pixels are only taken while the sequencer is idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == S_IDLE)
    else $error("word accepted while sequencer busy");

  // The divider remainder stays below a non-zero divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !div_zero) |-> div_rem < div_n)
    else $error("divider remainder out of range");

  // A report leaves the histogram empty.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && finish && !res_busy) |=> vld == '0)
    else $error("histogram not cleared after report");

  // Reports carry a zero pixel and the held threshold.
  a_report: assert property (@(posedge clk) disable iff (rst)
    (res_valid && result_kind == KIND_REPORT) |->
      (binary_pixel == BLACK && threshold_value == held))
    else $error("malformed threshold report");

endmodule
